// ===== sv/settings_header_parser_unit_assert.svh =====
// ----------------------------------------------------------------------------
// settings header parser assertion macros
// concurrent assertion wrappers shared by the rtl files of the parser
// ----------------------------------------------------------------------------
`ifndef SETTINGS_HEADER_PARSER_UNIT_ASSERT_SVH
`define SETTINGS_HEADER_PARSER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property must hold on every clock edge outside reset
`define SHPU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("shpu assertion failed");

// condition must never be seen outside reset
`define SHPU_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("shpu forbidden condition seen");

`else

`define SHPU_ASSERT(lbl, clk, rstn, prop)
`define SHPU_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ===== sv/shpu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shpu_pkg
// types, character codes and the type name table of the settings header parser
// ----------------------------------------------------------------------------
package shpu_pkg;

  // characters of the header syntax
  localparam logic [7:0] CharOpen  = 8'h3C;
  localparam logic [7:0] CharClose = 8'h3E;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  // result kinds
  localparam logic [1:0] KindId       = 2'd0;
  localparam logic [1:0] KindNameChar = 2'd1;
  localparam logic [1:0] KindNameEnd  = 2'd2;
  localparam logic [1:0] KindType     = 2'd3;

  // type token limits
  localparam logic [3:0] TokenMax  = 4'd8;
  localparam logic [3:0] TokenOver = 4'd9;
  localparam int         TypeCount = 17;
  localparam logic [4:0] TypeUnknown = 5'd17;

  // type names, last character in the lowest byte (shift-in order)
  localparam logic [63:0] TypeNames [TypeCount] = '{
    64'("INT"), 64'("UINT"), 64'("FLOAT"), 64'("DOUBLE"), 64'("R_FLOAT"),
    64'({"R_", "DOUBLE"}), 64'("R_INT"), 64'("R_UINT"), 64'("DL_STR"), 64'("DL_INT"),
    64'({"DL_", "FLOAT"}), 64'("SL_STR"), 64'("SL_INT"), 64'({"SL_", "FLOAT"}),
    64'("STR"), 64'("TOG"), 64'("DEBUG")
  };

  localparam logic [3:0] TypeLens [TypeCount] = '{
    4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd5, 4'd6, 4'd6,
    4'd6, 4'd8, 4'd6, 4'd6, 4'd8, 4'd3, 4'd3, 4'd5
  };

  // parse stages
  typedef enum logic [3:0] {
    ST_SEEK_ID    = 4'd0,
    ST_IN_ID      = 4'd1,
    ST_SEEK_NAME  = 4'd2,
    ST_IN_NAME    = 4'd3,
    ST_SEEK_TYPE  = 4'd4,
    ST_IN_TYPE    = 4'd5,
    ST_SEEK_VALUE = 4'd6,
    ST_IN_VALUE   = 4'd7,
    ST_DONE       = 4'd8
  } stage_e;

  // commands from the front to the back
  typedef enum logic [3:0] {
    OP_NONE       = 4'd0,
    OP_ID_CLEAR   = 4'd1,
    OP_ID_DIGIT   = 4'd2,
    OP_ID_EMIT    = 4'd3,
    OP_NAME_CHAR  = 4'd4,
    OP_NAME_END   = 4'd5,
    OP_TYPE_CLEAR = 4'd6,
    OP_TYPE_BYTE  = 4'd7,
    OP_TYPE_EMIT  = 4'd8
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } cmd_t;

  // match a shifted-in token against the name table
  function automatic logic [4:0] resolve_type(logic [63:0] tok, logic [3:0] len);
    logic [4:0] code;
    code = TypeUnknown;
    for (int k = TypeCount - 1; k >= 0; k--) begin
      if (len == TypeLens[k] && tok == TypeNames[k]) begin
        code = 5'(k);
      end
    end
    return code;
  endfunction

endpackage

// ===== sv/shpu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shpu_front
// tracks the parse stage and turns input words into back-end commands where one applies
// ----------------------------------------------------------------------------
module shpu_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_char_i,
  input  logic              in_last_i,
  output logic              cmd_valid_o,
  output shpu_pkg::cmd_t    cmd_o,
  input  logic              cmd_ready_i
);
  import shpu_pkg::*;

  stage_e stage_q, stage_d;
  stage_e stage_next;
  logic   accept;
  op_e    op;
  logic   is_digit;

  assign in_ready_o = cmd_ready_i;
  assign accept     = in_valid_i & cmd_ready_i;
  assign is_digit   = in_char_i inside {[CharZero:CharNine]};

  // next stage from the current character
  always_comb begin
    stage_next = stage_q;
    case (stage_q)
      ST_SEEK_ID:    if (in_char_i == CharOpen)  stage_next = ST_IN_ID;
      ST_IN_ID:      if (in_char_i == CharClose) stage_next = ST_SEEK_NAME;
      ST_SEEK_NAME:  if (in_char_i == CharOpen)  stage_next = ST_IN_NAME;
      ST_IN_NAME:    if (in_char_i == CharClose) stage_next = ST_SEEK_TYPE;
      ST_SEEK_TYPE:  if (in_char_i == CharOpen)  stage_next = ST_IN_TYPE;
      ST_IN_TYPE:    if (in_char_i == CharClose) stage_next = ST_SEEK_VALUE;
      ST_SEEK_VALUE: if (in_char_i == CharColon) stage_next = ST_IN_VALUE;
      ST_IN_VALUE:   if (in_char_i == CharColon) stage_next = ST_DONE;
      default:       stage_next = stage_q;
    endcase
    stage_d = stage_q;
    if (accept) begin
      stage_d = in_last_i ? ST_SEEK_ID : stage_next;
    end
  end

  // command for the current character
  always_comb begin
    op = OP_NONE;
    case (stage_q)
      ST_SEEK_ID:   if (in_char_i == CharOpen) op = OP_ID_CLEAR;
      ST_IN_ID: begin
        if (in_char_i == CharClose) op = OP_ID_EMIT;
        else if (is_digit)          op = OP_ID_DIGIT;
      end
      ST_IN_NAME:   op = (in_char_i == CharClose) ? OP_NAME_END : OP_NAME_CHAR;
      ST_SEEK_TYPE: if (in_char_i == CharOpen) op = OP_TYPE_CLEAR;
      ST_IN_TYPE:   op = (in_char_i == CharClose) ? OP_TYPE_EMIT : OP_TYPE_BYTE;
      default:      op = OP_NONE;
    endcase
    cmd_valid_o = accept && (op != OP_NONE);
    cmd_o.op    = op;
    cmd_o.data  = (op == OP_ID_DIGIT) ? (in_char_i - CharZero) : in_char_i;
  end

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= ST_SEEK_ID;
    end else begin
      stage_q <= stage_d;
    end
  end

endmodule

// ===== sv/shpu_cmd_fifo.sv =====
`timescale 1ns / 1ps
`include "settings_header_parser_unit_assert.svh"
// ----------------------------------------------------------------------------
// shpu_cmd_fifo
// short command queue between the front and the back of the parser
// ----------------------------------------------------------------------------
module shpu_cmd_fifo #(
  parameter int Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  shpu_pkg::cmd_t    push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              rd_valid_o,
  output shpu_pkg::cmd_t    rd_data_o
);
  import shpu_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & rd_valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset on payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // queue checks
  `SHPU_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(Depth))
  `SHPU_ASSERT(a_count_up, clk_i, rst_ni, (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
  `SHPU_ASSERT_NEVER(a_ptr_skew, clk_i, rst_ni, (count_q == '0) && (wr_ptr_q != rd_ptr_q))

endmodule

// ===== sv/shpu_back.sv =====
`timescale 1ns / 1ps
`include "settings_header_parser_unit_assert.svh"
// ----------------------------------------------------------------------------
// shpu_back
// executes parser commands: id accumulation, type token matching, results
// ----------------------------------------------------------------------------
module shpu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  shpu_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        out_kind_o,
  output logic [63:0]       out_value_o
);
  import shpu_pkg::*;

  logic [63:0] id_q, id_d;
  logic [63:0] tok_q, tok_d;
  logic [3:0]  len_q, len_d;
  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_kind_q, out_kind_d;
  logic [63:0] out_value_q, out_value_d;
  logic        pop;
  logic        emit;

  // take a command whenever the output word is free or leaving
  assign pop       = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign cmd_pop_o = pop;

  // command execution
  always_comb begin
    id_d        = id_q;
    tok_d       = tok_q;
    len_d       = len_q;
    emit        = 1'b0;
    out_kind_d  = out_kind_q;
    out_value_d = out_value_q;
    if (pop) begin
      case (cmd_i.op)
        OP_ID_CLEAR: id_d = '0;
        OP_ID_DIGIT: id_d = (id_q << 3) + (id_q << 1) + {60'd0, cmd_i.data[3:0]};
        OP_ID_EMIT: begin
          emit        = 1'b1;
          out_kind_d  = KindId;
          out_value_d = id_q;
        end
        OP_NAME_CHAR: begin
          emit        = 1'b1;
          out_kind_d  = KindNameChar;
          out_value_d = {56'd0, cmd_i.data};
        end
        OP_NAME_END: begin
          emit        = 1'b1;
          out_kind_d  = KindNameEnd;
          out_value_d = '0;
        end
        OP_TYPE_CLEAR: begin
          tok_d = '0;
          len_d = '0;
        end
        OP_TYPE_BYTE: begin
          // bytes shift in from the low end, matching the name table
          if (len_q < TokenMax) begin
            tok_d = {tok_q[55:0], cmd_i.data};
            len_d = len_q + 1'b1;
          end else begin
            len_d = TokenOver;
          end
        end
        OP_TYPE_EMIT: begin
          emit        = 1'b1;
          out_kind_d  = KindType;
          out_value_d = {59'd0, resolve_type(tok_q, len_q)};
        end
        default: emit = 1'b0;
      endcase
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q        <= '0;
      tok_q       <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      id_q        <= id_d;
      tok_q       <= tok_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output word payload
  always_ff @(posedge clk_i) begin
    out_kind_q  <= out_kind_d;
    out_value_q <= out_value_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_value_o = out_value_q;

  // execution checks
  `SHPU_ASSERT(a_len_range, clk_i, rst_ni, len_q <= TokenOver)
  `SHPU_ASSERT(a_type_code, clk_i, rst_ni, (out_valid_q && out_kind_q == KindType) |-> (out_value_q <= 64'd17))
  `SHPU_ASSERT(a_name_end_zero, clk_i, rst_ni, (out_valid_q && out_kind_q == KindNameEnd) |-> (out_value_q == 64'd0))

endmodule

// ===== sv/settings_header_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// settings_header_parser_unit
// streaming parser for <ID><NAME><TYPE>:VALUE: settings headers
// ----------------------------------------------------------------------------
// One character word is taken per cycle, back to back, and each word gives at
// most one result word: the decimal id at its closing '>', every name
// character, a name end marker, and the type code (0..16, 17 for unknown) at
// the type's closing '>'. The front stage tracks the parse position and hands
// commands to a CmdDepth-entry queue; the back stage executes one command per
// cycle while its output register is free or being taken (the id multiply by
// ten and add, the type token shift and name match) into that register, so a
// result is held in the queue and then in the output register. Input stalls
// only when the queue fills while results are not being taken. tlast on a
// character returns the parser to its start state after that character.
module settings_header_parser_unit #(
  parameter int CmdDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // character input
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_byte
  input  logic        s_axis_tlast_i,   // last_byte
  // result output
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [63:0] field_value
  output logic [1:0]  m_axis_tuser_o    // [1:0] field_kind
);
  import shpu_pkg::*;

  logic cmd_push;
  cmd_t cmd_push_data;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_valid;
  cmd_t cmd_data;

  // classify incoming characters
  shpu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_char_i   (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .cmd_valid_o (cmd_push),
    .cmd_o       (cmd_push_data),
    .cmd_ready_i (~cmd_full)
  );

  // decoupling queue
  shpu_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .push_data_i (cmd_push_data),
    .full_o      (cmd_full),
    .pop_i       (cmd_pop),
    .rd_valid_o  (cmd_valid),
    .rd_data_o   (cmd_data)
  );

  // execute commands and drive results
  shpu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_data),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_kind_o  (m_axis_tuser_o),
    .out_value_o (m_axis_tdata_o)
  );

endmodule
